### rtl/positional_array_list_engine_unit_macros.svh
// Assertion macros for the positional array list engine.
`ifndef POSITIONAL_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// lbl: antecedent implies consequent in the same cycle
`define PALE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// lbl: antecedent implies consequent in the next cycle
`define PALE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PALE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PALE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### rtl/pale_pkg.sv
// Shared constants for the positional array list engine.
package pale_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int ELEM_W_DEF = 32;

  localparam int CNT_W  = 7;   // position, length, capacity
  localparam int VAL_W  = 32;  // value fields on the ports
  localparam int ACT_W  = 3;
  localparam int WIDE_W = 64;  // sign extension scratch width

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ      = 3'd2;
  localparam logic [ACT_W-1:0] ACT_OVERWRITE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SEARCH    = 3'd4;

endpackage

### rtl/pale_ram.sv
// Generic single write port RAM with registered read.
module pale_ram
  import pale_pkg::*;
#(
  parameter int WIDTH = ELEM_W_DEF,
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/positional_array_list_engine_unit.sv
// Top level of the positional array list engine: sequencer, list RAM and output word.
//
//  channel | ports                     | contents
//  --------+---------------------------+----------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser | tuser: action; tdata: position, value
//  out     | out_tvalid/tready/tdata   | ok, read_value, match_position, length, full
//  cfg     | cfg_we/cfg_wdata          | capacity (write only)
//
// Steps per word: overwrite and failed actions accept, then finish; read accepts, addresses
// the RAM, takes the read data, then finishes. Insert and remove shift the entries behind the
// position one by one; search compares entries from the given position until a match or the
// end of the list. The list RAM with its one read and one write port sets this: one entry moved or compared per cycle.
// Reset (rst_n low, synchronous) empties the list and sets capacity to 64; no RAM clearing.
// in_tready is high only while idle; a finished word waits in the output register, and the
// next input word is taken meanwhile. A stalled output holds the sequencer in its last step.
`include "positional_array_list_engine_unit_macros.svh"

module positional_array_list_engine_unit
  import pale_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int ELEMENT_WIDTH = ELEM_W_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [6:0] position, [38:7] value, [39] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: [2:0] action
  input  logic [ACT_W-1:0]      in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // out_tdata: [0] ok, [32:1] read_value, [39:33] match_position,
  //            [46:40] length, [47] full_res
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CNT_W-1:0]      cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (AW > CNT_W) ? AW : CNT_W;
  localparam int EW    = ELEMENT_WIDTH;
  localparam int DCLIP = (DEPTH > 127) ? 127 : DEPTH;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DCLIP);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INS  = 7'b0000010,
    ST_DEL  = 7'b0000100,
    ST_RDA  = 7'b0001000,
    ST_RDW  = 7'b0010000,
    ST_SRCH = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  function automatic logic [AW-1:0] to_addr(input logic [CNT_W-1:0] i);
    logic [IW-1:0] w;
    w = IW'(i);
    return w[AW-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  cap_r;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [EW-1:0]     v_r, v_nxt;
  logic              ok_r, ok_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  wtgt_r, wtgt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [VAL_W-1:0]  rd_val_r, rd_val_nxt;
  logic [CNT_W-1:0]  match_r, match_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // RAM port signals
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;

  // Input word fields
  logic [CNT_W-1:0]  in_pos;
  logic [VAL_W-1:0]  in_val;
  logic signed [VAL_W-1:0]  in_val_s;
  logic signed [WIDE_W-1:0] in_wide;
  logic [EW-1:0]     in_elem;

  // Entry sign extension for read results
  logic signed [EW-1:0]     rd_s;
  logic signed [WIDE_W-1:0] rd_wide;

  logic [CNT_W-1:0]  cap_eff;
  logic              pos_ok, ins_ok;
  logic [CNT_W:0]    count_p1;

  // Shared pointer step and compare
  logic [CNT_W-1:0]  step_sum;
  logic              ptr_lt_cnt;
  logic [CNT_W-1:0]  len;
  logic              fin_go;

  assign in_pos   = in_tdata[6:0];
  assign in_val   = in_tdata[38:7];
  assign in_val_s = signed'(in_val);
  assign in_wide  = WIDE_W'(in_val_s);
  assign in_elem  = in_wide[EW-1:0];

  assign rd_s    = signed'(ram_rdata);
  assign rd_wide = WIDE_W'(rd_s);

  assign cap_eff  = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;
  assign count_p1 = {1'b0, count_r} + 1'b1;
  assign pos_ok   = (in_pos != '0) && (in_pos <= count_r);
  assign ins_ok   = (count_r < cap_eff) && (in_pos != '0) && ({1'b0, in_pos} <= count_p1);

  // Insert walks down, remove and search walk up
  assign step_sum   = (state_r == ST_INS) ? (ptr_r - 1'b1) : (ptr_r + 1'b1);
  assign ptr_lt_cnt = ptr_r < count_r;

  assign fin_go = !out_tvalid_r || out_tready;

  always_comb begin
    len = count_r;
    if (ok_r && (act_r == ACT_INSERT)) begin
      len = count_r + 1'b1;
    end else if (ok_r && (act_r == ACT_REMOVE)) begin
      len = count_r - 1'b1;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    act_nxt        = act_r;
    p_nxt          = p_r;
    v_nxt          = v_r;
    ok_nxt         = ok_r;
    ptr_nxt        = ptr_r;
    wtgt_nxt       = wtgt_r;
    rd_vld_nxt     = rd_vld_r;
    rd_val_nxt     = rd_val_r;
    match_nxt      = match_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    ram_waddr      = to_addr(p_r);
    ram_wdata      = v_r;
    ram_raddr      = to_addr(p_r);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_tuser;
          p_nxt      = in_pos - 1'b1;
          v_nxt      = in_elem;
          ok_nxt     = 1'b0;
          rd_vld_nxt = 1'b0;
          rd_val_nxt = '0;
          match_nxt  = '0;
          state_nxt  = ST_FIN;
          case (in_tuser)
            ACT_INSERT: begin
              if (ins_ok) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = count_r;
                state_nxt = ST_INS;
              end
            end
            ACT_REMOVE: begin
              if (pos_ok) begin
                ok_nxt    = 1'b1;
                ptr_nxt   = in_pos;
                state_nxt = ST_DEL;
              end
            end
            ACT_READ: begin
              if (pos_ok) begin
                ok_nxt    = 1'b1;
                state_nxt = ST_RDA;
              end
            end
            ACT_OVERWRITE: begin
              if (pos_ok) begin
                ok_nxt    = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = to_addr(in_pos - 1'b1);
                ram_wdata = in_elem;
              end
            end
            ACT_SEARCH: begin
              ptr_nxt   = (in_pos == '0) ? '0 : (in_pos - 1'b1);
              state_nxt = ST_SRCH;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_INS: begin
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = to_addr(wtgt_r);
          ram_wdata = ram_rdata;
        end
        if (ptr_r != p_r) begin
          ram_raddr  = to_addr(step_sum);
          wtgt_nxt   = ptr_r;
          ptr_nxt    = step_sum;
          rd_vld_nxt = 1'b1;
        end else if (rd_vld_r) begin
          rd_vld_nxt = 1'b0;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = to_addr(p_r);
          ram_wdata = v_r;
          state_nxt = ST_FIN;
        end
      end

      ST_DEL: begin
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = to_addr(wtgt_r);
          ram_wdata = ram_rdata;
        end
        if (ptr_lt_cnt) begin
          ram_raddr  = to_addr(ptr_r);
          wtgt_nxt   = ptr_r - 1'b1;
          ptr_nxt    = step_sum;
          rd_vld_nxt = 1'b1;
        end else if (rd_vld_r) begin
          rd_vld_nxt = 1'b0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_RDA: begin
        ram_raddr = to_addr(p_r);
        state_nxt = ST_RDW;
      end

      ST_RDW: begin
        rd_val_nxt = rd_wide[VAL_W-1:0];
        state_nxt  = ST_FIN;
      end

      ST_SRCH: begin
        // wtgt_r holds the 1-based position of the entry now on the read port
        if (rd_vld_r && (ram_rdata == v_r)) begin
          ok_nxt     = 1'b1;
          match_nxt  = wtgt_r;
          rd_vld_nxt = 1'b0;
          state_nxt  = ST_FIN;
        end else if (ptr_lt_cnt) begin
          ram_raddr  = to_addr(ptr_r);
          ptr_nxt    = step_sum;
          wtgt_nxt   = step_sum;
          rd_vld_nxt = 1'b1;
        end else if (rd_vld_r) begin
          rd_vld_nxt = 1'b0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        if (fin_go) begin
          count_nxt      = len;
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {(len >= cap_eff), len, match_r, rd_val_r, ok_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      cap_r        <= CAP_RESET;
      rd_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    p_r         <= p_nxt;
    v_r         <= v_nxt;
    ok_r        <= ok_nxt;
    ptr_r       <= ptr_nxt;
    wtgt_r      <= wtgt_nxt;
    rd_val_r    <= rd_val_nxt;
    match_r     <= match_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  pale_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PALE_ASSERT_IMP(a_count_in_store, clk, rst_n, 1'b1, count_r <= DEPTH_C, "list length beyond store depth")
  `PALE_ASSERT_IMP(a_idle_no_read, clk, rst_n, in_tready, !rd_vld_r, "read in flight while idle")
  `PALE_ASSERT_NEXT(a_fin_emits, clk, rst_n, (state_r == ST_FIN) && fin_go, out_tvalid, "finished word not presented")

endmodule
